>>> src/salru_pkg.sv
// shared types and codes for the set-associative lru tag store
// no dependencies
package salru_pkg;

  // configuration register indexes and width
  localparam int CFG_W    = 4;
  localparam int CFG_AW   = 2;
  localparam logic [CFG_AW-1:0] REG_OFFSET_BITS    = 2'd0;
  localparam logic [CFG_AW-1:0] REG_SET_INDEX_BITS = 2'd1;
  localparam logic [CFG_AW-1:0] REG_WAYS_IN_USE    = 2'd2;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear;   // write one zeroed metadata row
    logic accept;  // capture address, start set read
    logic commit;  // write back the set and load the result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;  // clearing the final row
    logic out_free;    // result register can take a word
  } status_t;

endpackage

>>> src/set_assoc_cache_lru_lookup.sv
// top level of the set-associative tag store with true lru replacement
// depends on salru_pkg, salru_ctrl, salru_dpath and salru_ram
//
// Each input word is one byte address. It is split into block offset, set
// index and tag using the offset_bits and set_index_bits registers; the tag
// is compared against every valid way in use (ways_in_use) of the set. A hit
// makes that way most recently used; a miss fills the lowest invalid way or
// else evicts the least recently used one (lowest way on a rank tie). Every
// address yields one result word: hit, way, evicted_valid and the saturating
// running hit and miss counts including this access. An address is handled
// in an accept step, which reads the set row from the tag and metadata rams,
// and a lookup step, which compares, picks the way and writes the row back
// while the result register loads; no new address is taken until that
// write-back is done, and a stalled result holds the lookup. After reset a
// clearing pass zeroes valid bits and ranks one set per cycle over all
// MAX_SETS sets (512 by default), and no address is taken until it ends.
// Configuration writes are accepted at any time but are meant for idle
// periods; a write to an unknown register index is ignored.
module set_assoc_cache_lru_lookup
  import salru_pkg::*;
#(
  parameter int MAX_SETS   = 512,
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_AW-1:0]     cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  // address words in
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ADDR_WIDTH-1:0] in_addr,
  // result words out
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_hit,
  output logic [2:0]            out_way,
  output logic                  out_evicted_valid,
  output logic [31:0]           out_hit_count,
  output logic [31:0]           out_miss_count
);

  cmd_t    cmd;
  status_t st;

  // sequencer: clearing pass, then accept / lookup alternating
  salru_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st_i     (st),
    .cmd_o    (cmd)
  );

  // config, set rams, compare and lru update, counters, result register
  salru_dpath #(
    .MAX_SETS   (MAX_SETS),
    .MAX_WAYS   (MAX_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .in_addr           (in_addr),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_way           (out_way),
    .out_evicted_valid (out_evicted_valid),
    .out_hit_count     (out_hit_count),
    .out_miss_count    (out_miss_count),
    .cmd_i             (cmd),
    .st_o              (st)
  );

endmodule

>>> src/salru_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module salru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/salru_ctrl.sv
// sequencer for the lru tag store: clearing pass, accept, lookup/write-back
// depends on salru_pkg
module salru_ctrl
  import salru_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd_o        = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (st_i.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd_o.accept = 1'b1;
          state_nxt    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (st_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/salru_dpath.sv
// datapath of the lru tag store: config, address split, set rams, compare,
// victim choice, rank update, counters and result register
// depends on salru_pkg and salru_ram
module salru_dpath
  import salru_pkg::*;
#(
  parameter int MAX_SETS   = 512,
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_AW-1:0]     cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic [ADDR_WIDTH-1:0] in_addr,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic                  out_hit,
  output logic [2:0]            out_way,
  output logic                  out_evicted_valid,
  output logic [31:0]           out_hit_count,
  output logic [31:0]           out_miss_count,
  input  cmd_t                  cmd_i,
  output status_t               st_o
);

  localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RANK_W  = WAY_W;
  localparam int SIB_RAW = $clog2(MAX_SETS + 1) - 1;
  localparam int MAX_SIB = (SIB_RAW > 16) ? 16 : SIB_RAW;

  typedef struct packed {
    logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
    logic [MAX_WAYS-1:0]             valid;
  } meta_t;

  typedef logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_row_t;

  // configuration
  logic [CFG_W-1:0] offset_bits_r, set_bits_r, ways_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r <= CFG_W'(6);
      set_bits_r    <= CFG_W'(6);
      ways_r        <= CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_OFFSET_BITS:    offset_bits_r <= cfg_wdata;
        REG_SET_INDEX_BITS: set_bits_r    <= cfg_wdata;
        REG_WAYS_IN_USE:    ways_r        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // address split
  logic [4:0]            sib_c;
  logic [5:0]            tag_shift_c;
  logic [ADDR_WIDTH-1:0] shifted_c, idx_mask_c, set_full_c, tag_c;
  logic [SET_W-1:0]      set_c;

  always_comb begin
    sib_c       = ({1'b0, set_bits_r} > 5'(MAX_SIB)) ? 5'(MAX_SIB) : {1'b0, set_bits_r};
    shifted_c   = in_addr >> offset_bits_r;
    idx_mask_c  = (ADDR_WIDTH'(1) << sib_c) - ADDR_WIDTH'(1);
    set_full_c  = shifted_c & idx_mask_c;
    set_c       = set_full_c[SET_W-1:0];
    tag_shift_c = {2'b00, offset_bits_r} + {1'b0, sib_c};
    tag_c       = in_addr >> tag_shift_c;
  end

  logic [SET_W-1:0]      set_r;
  logic [ADDR_WIDTH-1:0] tag_r;

  always_ff @(posedge clk) begin
    if (cmd_i.accept) begin
      set_r <= set_c;
      tag_r <= tag_c;
    end
  end

  // clearing pass counter
  logic [SET_W-1:0] clr_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd_i.clear && !st_o.clear_last) begin
      clr_idx_r <= clr_idx_r + SET_W'(1);
    end
  end

  // set storage
  meta_t    meta_rd, meta_wr;
  tag_row_t tag_rd, tag_wr;
  logic     meta_we, tag_we;
  logic [SET_W-1:0] meta_waddr;

  salru_ram #(.WIDTH($bits(meta_t)), .DEPTH(MAX_SETS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wr),
    .re    (cmd_i.accept),
    .raddr (set_c),
    .rdata (meta_rd)
  );

  salru_ram #(.WIDTH($bits(tag_row_t)), .DEPTH(MAX_SETS)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (set_r),
    .wdata (tag_wr),
    .re    (cmd_i.accept),
    .raddr (set_c),
    .rdata (tag_rd)
  );

  // lookup
  logic [4:0]          ways5_c;
  logic [MAX_WAYS-1:0] in_use_c, match_c, free_c;
  logic                hit_c, found_c, evict_c, was_valid_c;
  logic [WAY_W-1:0]    hit_way_c, free_way_c, vic_way_c, way_c;
  logic [RANK_W-1:0]   vic_rank_c, old_rank_c;
  logic [3:0]          way4_c;

  always_comb begin
    if (ways_r == '0) begin
      ways5_c = 5'd1;
    end else if ({1'b0, ways_r} > 5'(MAX_WAYS)) begin
      ways5_c = 5'(MAX_WAYS);
    end else begin
      ways5_c = {1'b0, ways_r};
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_use_c[i] = (5'(i) < ways5_c);
      match_c[i]  = in_use_c[i] && meta_rd.valid[i] && (tag_rd[i] == tag_r);
      free_c[i]   = in_use_c[i] && !meta_rd.valid[i];
    end
    hit_c      = |match_c;
    found_c    = |free_c;
    hit_way_c  = '0;
    free_way_c = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (match_c[i]) hit_way_c = WAY_W'(i);
      if (free_c[i])  free_way_c = WAY_W'(i);
    end
    // largest rank, lowest way on a tie
    vic_way_c  = '0;
    vic_rank_c = meta_rd.rank[0];
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (in_use_c[i] && (meta_rd.rank[i] > vic_rank_c)) begin
        vic_way_c  = WAY_W'(i);
        vic_rank_c = meta_rd.rank[i];
      end
    end
    evict_c     = !hit_c && !found_c;
    way_c       = hit_c ? hit_way_c : (found_c ? free_way_c : vic_way_c);
    was_valid_c = meta_rd.valid[way_c];
    old_rank_c  = meta_rd.rank[way_c];
    way4_c      = 4'(way_c);
  end

  // rank update and write-back rows
  meta_t    meta_upd_c;

  always_comb begin
    meta_upd_c = meta_rd;
    tag_wr     = tag_rd;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (WAY_W'(i) == way_c) begin
        meta_upd_c.rank[i]  = '0;
        meta_upd_c.valid[i] = 1'b1;
        tag_wr[i]           = tag_r;
      end else if (in_use_c[i] && meta_rd.valid[i] &&
                   (!was_valid_c || (meta_rd.rank[i] < old_rank_c)) &&
                   (meta_rd.rank[i] < RANK_W'(MAX_WAYS - 1))) begin
        meta_upd_c.rank[i] = meta_rd.rank[i] + RANK_W'(1);
      end
    end
    meta_we    = cmd_i.clear || cmd_i.commit;
    meta_waddr = cmd_i.clear ? clr_idx_r : set_r;
    meta_wr    = cmd_i.clear ? '0 : meta_upd_c;
    tag_we     = cmd_i.commit && !hit_c;
  end

  // counters and result register
  logic [31:0] hit_cnt_r, miss_cnt_r;
  logic        out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
    end else if (cmd_i.commit) begin
      if (hit_c && (hit_cnt_r != '1)) begin
        hit_cnt_r <= hit_cnt_r + 32'd1;
      end
      if (!hit_c && (miss_cnt_r != '1)) begin
        miss_cnt_r <= miss_cnt_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.commit) begin
      out_hit           <= hit_c;
      out_way           <= way4_c[2:0];
      out_evicted_valid <= evict_c;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit_count  = hit_cnt_r;
  assign out_miss_count = miss_cnt_r;

  assign st_o.clear_last = (clr_idx_r == SET_W'(MAX_SETS - 1));
  assign st_o.out_free   = !out_valid_r || !out_stall;

  // a commit never overwrites a word still waiting downstream
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.commit |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while stalled");

  // counters move only on a committed lookup
  a_cnt_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd_i.commit |=> ($stable(hit_cnt_r) && $stable(miss_cnt_r)))
    else $error("hit or miss count changed without a lookup");

  // the way hit or filled lies inside the ways in use
  a_way_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.commit |-> ({1'b0, way4_c} < ways5_c))
    else $error("selected way outside the ways in use");

endmodule

>>> sim/set_assoc_cache_lru_lookup_tb.sv
// self-checking testbench for the set-associative tag store with lru replacement
// depends on salru_pkg and the set_assoc_cache_lru_lookup rtl
// drives address words through phases of register settings and compares every result word
`timescale 1ns / 100ps

module set_assoc_cache_lru_lookup_tb;
  import salru_pkg::*;

  localparam int MAX_SETS   = 512;
  localparam int MAX_WAYS   = 8;
  localparam int ADDR_WIDTH = 32;
  localparam int LINES      = MAX_SETS * MAX_WAYS;

  // no such register in the block, writes must be dropped
  localparam logic [CFG_AW-1:0] REG_UNUSED = 2'd3;

  localparam int RAND_PHASES     = 10;
  localparam int WORDS_PER_PHASE = 200;
  localparam int MAX_REPORTS     = 10;

  // how the two sides hold off during a phase
  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  // one result word as the block reports it
  typedef struct packed {
    logic        hit;
    logic [2:0]  way;
    logic        evicted_valid;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
  } lookup_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_AW-1:0]     cfg_addr = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ADDR_WIDTH-1:0] in_addr = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_hit;
  logic [2:0]            out_way;
  logic                  out_evicted_valid;
  logic [31:0]           out_hit_count;
  logic [31:0]           out_miss_count;

  set_assoc_cache_lru_lookup #(
    .MAX_SETS  (MAX_SETS),
    .MAX_WAYS  (MAX_WAYS),
    .ADDR_WIDTH(ADDR_WIDTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_addr          (in_addr),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_way          (out_way),
    .out_evicted_valid(out_evicted_valid),
    .out_hit_count    (out_hit_count),
    .out_miss_count   (out_miss_count)
  );

  // ---------------------------------------------------------------------------
  // shadow copy of the tag store and its registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] shadow_offset_bits = 4'd6;
  logic [CFG_W-1:0] shadow_set_bits    = 4'd6;
  logic [CFG_W-1:0] shadow_ways        = 4'd1;

  bit          shadow_valid [LINES];
  logic [31:0] shadow_tag   [LINES];
  logic [2:0]  shadow_rank  [LINES];
  logic [31:0] shadow_hits   = '0;
  logic [31:0] shadow_misses = '0;

  logic [ADDR_WIDTH-1:0] pending_addrs[$];
  lookup_result_t        expected_results[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int words_sent     = 0;
  int words_checked  = 0;

  // set bits beyond what MAX_SETS can hold are clamped
  function automatic int unsigned used_set_bits();
    int unsigned k;
    k = 0;
    while ((2 << k) <= MAX_SETS) k++;
    return (shadow_set_bits > k) ? k : shadow_set_bits;
  endfunction

  // zero ways means one, more than MAX_WAYS means all of them
  function automatic int unsigned used_ways();
    if (shadow_ways == 0) return 1;
    if (shadow_ways > MAX_WAYS) return MAX_WAYS;
    return shadow_ways;
  endfunction

  // one lookup against the shadow store; updates it and returns the result word
  function automatic lookup_result_t lookup_and_update(logic [31:0] addr);
    int unsigned    sib, ways, set_no, base, w, i;
    logic [31:0]    tag;
    logic [2:0]     old_rank;
    bit             hit, found, evicted, was_valid;
    lookup_result_t res;
    sib     = used_set_bits();
    ways    = used_ways();
    set_no  = (addr >> shadow_offset_bits) & ((32'd1 << sib) - 1);
    tag     = addr >> (shadow_offset_bits + sib);
    base    = set_no * MAX_WAYS;
    hit     = 0;
    found   = 0;
    evicted = 0;
    w       = 0;

    // lowest matching way wins when reconfiguration left duplicates
    for (i = 0; i < ways && !hit; i++) begin
      if (shadow_valid[base+i] && shadow_tag[base+i] == tag) begin
        hit = 1;
        w   = i;
      end
    end

    if (hit) begin
      if (shadow_hits != 32'hFFFF_FFFF) shadow_hits++;
    end else begin
      if (shadow_misses != 32'hFFFF_FFFF) shadow_misses++;
      for (i = 0; i < ways && !found; i++) begin
        if (!shadow_valid[base+i]) begin
          found = 1;
          w     = i;
        end
      end
      // victim: highest rank, lowest way on a tie
      if (!found) begin
        w = 0;
        for (i = 1; i < ways; i++)
          if (shadow_rank[base+i] > shadow_rank[base+w]) w = i;
        evicted = 1;
      end
    end

    // rank update: ways younger than the touched one, or every valid way when it was empty, age by one
    was_valid = shadow_valid[base+w];
    old_rank  = shadow_rank[base+w];
    for (i = 0; i < ways; i++) begin
      if (i != w && shadow_valid[base+i] && (!was_valid || shadow_rank[base+i] < old_rank))
        if (shadow_rank[base+i] < MAX_WAYS - 1) shadow_rank[base+i]++;
    end
    shadow_rank[base+w] = '0;
    if (!hit) begin
      shadow_valid[base+w] = 1;
      shadow_tag[base+w]   = tag;
    end

    res.hit           = hit;
    res.way           = w[2:0];
    res.evicted_valid = evicted;
    res.hit_count     = shadow_hits;
    res.miss_count    = shadow_misses;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // clock and the hard limit on run length
  // ---------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  // slowest legal run is well under a tenth of this
  initial begin
    #5_000_000;
    $display("timeout with %0d words still expected", expected_results.size());
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // address driver: presents queued words, predicts each one on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
      // stalled word stays put
    end else begin
      if (in_valid) begin
        expected_results.push_back(lookup_and_update(in_addr));
        words_sent++;
      end
      if (pending_addrs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_addr  <= pending_addrs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: random stall, compares each accepted word with the oldest
  // prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    lookup_result_t got;
    lookup_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.hit           = out_hit;
        got.way           = out_way;
        got.evicted_valid = out_evicted_valid;
        got.hit_count     = out_hit_count;
        got.miss_count    = out_miss_count;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: result word with none expected: hit %0b way %0d ev %0b h %0d m %0d",
                     $realtime, got.hit, got.way, got.evicted_valid, got.hit_count,
                     got.miss_count);
        end else begin
          want = expected_results.pop_front();
          words_checked++;
          if (got.hit !== want.hit || got.way !== want.way
              || got.evicted_valid !== want.evicted_valid
              || got.hit_count !== want.hit_count || got.miss_count !== want.miss_count) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("%0t: word %0d mismatch", $realtime, words_checked);
              $display("  expected hit %0b way %0d ev %0b hits %0d misses %0d",
                       want.hit, want.way, want.evicted_valid, want.hit_count,
                       want.miss_count);
              $display("  actual   hit %0b way %0d ev %0b hits %0d misses %0d",
                       got.hit, got.way, got.evicted_valid, got.hit_count, got.miss_count);
            end
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // sequencing helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_OFFSET_BITS:    shadow_offset_bits = val;
      REG_SET_INDEX_BITS: shadow_set_bits    = val;
      REG_WAYS_IN_USE:    shadow_ways        = val;
      default: ;
    endcase
  endtask

  task automatic set_geometry(int unsigned off, int unsigned sib, int unsigned ways);
    write_reg(REG_OFFSET_BITS, off[CFG_W-1:0]);
    write_reg(REG_SET_INDEX_BITS, sib[CFG_W-1:0]);
    write_reg(REG_WAYS_IN_USE, ways[CFG_W-1:0]);
  endtask

  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 60; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 60; end
      default:   begin send_idle_pct = 25; recv_stall_pct = 25; end
    endcase
  endtask

  // block goes idle once every queued word is through and every result is back;
  // checked between edges so the driver and monitor updates have settled
  task automatic drain();
    while (pending_addrs.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  int unsigned phase_off  [RAND_PHASES] = '{0, 12, 6, 3, 15, 2, 5, 8, 4, 1};
  int unsigned phase_sib  [RAND_PHASES] = '{0, 9, 6, 2, 15, 4, 1, 3, 3, 5};
  int unsigned phase_ways [RAND_PHASES] = '{1, 8, 4, 2, 3, 5, 8, 7, 0, 12};

  initial begin : stimulus
    int unsigned hot_sets[4];
    int unsigned n_hot, n_tags, sib, shift, p, k;
    logic [31:0] tag_base, tag, a;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // registers back to their reset values, the clearing pass runs meanwhile
    set_geometry(6, 6, 1);
    set_idling(IDLE_NONE);

    // direct-mapped: cold miss, hit in the same block, top address, eviction
    pending_addrs = '{32'h0000_0000, 32'h0000_003F, 32'hFFFF_FFFF, 32'h0000_1000};
    drain();

    // two ways: fill an empty way, hit the other, evict the older one
    write_reg(REG_WAYS_IN_USE, 4'd2);
    pending_addrs = '{32'h0000_2000, 32'h0000_1000, 32'h0000_3000};
    drain();

    // shrink to one way so the same tag lands in way 0 as well, then
    // widen again: two ways now match and the lower one must win
    write_reg(REG_WAYS_IN_USE, 4'd1);
    pending_addrs = '{32'h0000_3000};
    drain();
    write_reg(REG_WAYS_IN_USE, 4'd2);
    pending_addrs = '{32'h0000_3000};
    drain();

    // zero ways, set bits past the limit, largest offset
    set_geometry(15, 15, 0);
    pending_addrs = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000};
    drain();

    // ways above the maximum on a single set; the stray register write must
    // not disturb anything
    set_geometry(0, 0, 15);
    write_reg(REG_UNUSED, 4'hF);
    for (k = 0; k < 9; k++) pending_addrs.push_back(k);
    pending_addrs.push_back(32'h0000_0000);
    drain();

    // random phases: mostly a small working set per phase so sets fill,
    // hit and evict; the rest is arbitrary addresses
    for (p = 0; p < RAND_PHASES; p++) begin
      set_geometry(phase_off[p], phase_sib[p], phase_ways[p]);
      set_idling(idle_mode_t'(p % 4));
      sib      = used_set_bits();
      shift    = shadow_offset_bits + sib;
      n_hot    = $urandom_range(1, 3);
      n_tags   = used_ways() + $urandom_range(0, 3);
      tag_base = $urandom;
      for (k = 0; k < n_hot; k++) hot_sets[k] = $urandom_range(0, (1 << sib) - 1);
      for (k = 0; k < WORDS_PER_PHASE; k++) begin
        if ($urandom_range(99) < 75) begin
          tag = tag_base + $urandom_range(0, n_tags - 1);
          a   = (tag << shift)
              | (hot_sets[$urandom_range(0, n_hot - 1)] << shadow_offset_bits)
              | ($urandom & ((32'd1 << shadow_offset_bits) - 1));
        end else begin
          a = $urandom;
        end
        pending_addrs.push_back(a);
      end
      drain();
    end

    // stray results after the last one would show up here
    repeat (20) @(posedge clk);
    $display("%0d address words over %0d register settings, %0d hits and %0d misses checked",
             words_sent, RAND_PHASES + 6, shadow_hits, shadow_misses);
    $display("%0d result words compared, %0d failures", words_checked, fail_count);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
